[hw/rtl/sie_pkg.sv]
`default_nettype none

package sie_pkg;

    // Default size of the variable file.
    localparam int SIE_VAR_COUNT = 64;

    // Largest script the instruction store can hold; the configured length is clipped to it.
    localparam int SIE_PROG_DEPTH = 2048;

    typedef logic signed [31:0] t_q;    // Q16.16 value
    typedef logic [11:0]        t_pc;   // program counter and program length
    typedef logic [5:0]         t_idx;  // variable index as carried in a request

    localparam t_q Q_MAX = 32'sh7fff_ffff;
    localparam t_q Q_MIN = 32'sh8000_0000;

    // Result of the divider, valid in the cycle where done is high.
    typedef struct packed {
        logic done;
        logic fault;
        t_q   quot;
    } t_div_res;

endpackage

`default_nettype wire

[hw/rtl/sie_ram.sv]
`default_nettype none

module sie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/sie_div.sv]
`default_nettype none

module sie_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  sie_pkg::t_q        i_dividend,
    input  sie_pkg::t_q        i_divisor,
    output sie_pkg::t_div_res  o_res
);

    import sie_pkg::*;

    // Computes saturate((a * 2^16) / b), truncating toward zero, one quotient bit per cycle.
    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_SAT,
        D_FIN
    } t_dstate;

    t_dstate     r_state;
    logic        r_neg;
    logic [31:0] r_den;
    logic [31:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [4:0]  r_cnt;
    t_q          r_quot;
    logic        r_fault;

    logic [31:0] w_abs_a;
    logic [31:0] w_abs_b;
    logic [32:0] w_trial;
    logic [32:0] w_diff;

    assign w_abs_a = i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
    assign w_abs_b = i_divisor[31]  ? (32'd0 - i_divisor)  : i_divisor;
    assign w_trial = {r_rem, r_num[31]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_neg   <= i_dividend[31] ^ i_divisor[31];
                        r_den   <= w_abs_b;
                        r_num   <= {w_abs_a[15:0], 16'd0};
                        r_rem   <= {16'd0, w_abs_a[31:16]};
                        r_quo   <= '0;
                        r_cnt   <= '0;
                        r_fault <= 1'b1;
                        if (i_divisor == '0) begin
                            // Division by zero saturates in the direction of the dividend.
                            if (i_dividend == '0) begin
                                r_quot <= '0;
                            end else if (i_dividend[31]) begin
                                r_quot <= Q_MIN;
                            end else begin
                                r_quot <= Q_MAX;
                            end
                            r_state <= D_FIN;
                        end else if ({16'd0, w_abs_a[31:16]} >= w_abs_b) begin
                            // The quotient needs more than 32 bits, so it saturates.
                            r_quot  <= (i_dividend[31] ^ i_divisor[31]) ? Q_MIN : Q_MAX;
                            r_state <= D_FIN;
                        end else begin
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    if (!w_diff[32]) begin
                        r_rem <= w_diff[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_num <= {r_num[30:0], 1'b0};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= D_SAT;
                    end
                end
                D_SAT: begin
                    if (r_neg) begin
                        if (r_quo > 32'h8000_0000) begin
                            r_quot  <= Q_MIN;
                            r_fault <= 1'b1;
                        end else begin
                            r_quot  <= 32'd0 - r_quo;
                            r_fault <= 1'b0;
                        end
                    end else begin
                        if (r_quo[31]) begin
                            r_quot  <= Q_MAX;
                            r_fault <= 1'b1;
                        end else begin
                            r_quot  <= r_quo;
                            r_fault <= 1'b0;
                        end
                    end
                    r_state <= D_FIN;
                end
                D_FIN: begin
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    assign o_res.done  = (r_state == D_FIN);
    assign o_res.fault = r_fault;
    assign o_res.quot  = r_quot;

endmodule

`default_nettype wire

[hw/rtl/script_instruction_executor_core.sv]
`default_nettype none

// Script instruction executor. Each request carries one script instruction (assign, arithmetic,
// branch if false, jump, no-op) or a host access (write or read of one variable), and each
// request produces exactly one result with the program counter after it, the finished flag,
// the value written or read, and the write, branch and fault flags. Values are Q16.16 and
// every arithmetic result saturates to 32 bits; division by zero saturates and sets the fault
// flag. The block works on one request at a time: operands are fetched from the variable
// file through its single read port one after the other, and the instruction then runs in a
// small sequencer. Every request passes through the states S_RDA, S_RDB, S_LDB, S_EXEC and
// S_DONE; multiply also passes through S_MUL, because the product is registered before it is
// saturated, and divide waits in S_DIV for the restoring divider, which retires one quotient
// bit per cycle and skips that loop when the divisor is zero or the quotient is known to
// overflow. After reset the variable file is cleared one entry per cycle, and the block
// accepts its first request only once the clearing pass is over. The result
// sits in an output register, so a new request is taken while the previous result still
// waits to be taken. The program length register lies at byte address 0 of the APB port and
// should be written only while the block is idle.
module script_instruction_executor_core #(
    parameter int VAR_COUNT = sie_pkg::SIE_VAR_COUNT
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,

    // Request channel.
    input  wire logic   i_in_valid,
    output logic        o_in_stall,
    input  wire logic [2:0] i_opcode,
    input  sie_pkg::t_idx   i_dest_index,
    input  wire logic       i_a_from_var,
    input  sie_pkg::t_idx   i_a_index,
    input  sie_pkg::t_q     i_a_literal,
    input  wire logic       i_b_from_var,
    input  sie_pkg::t_idx   i_b_index,
    input  sie_pkg::t_q     i_b_literal,
    input  wire logic [2:0] i_operator_code,
    input  sie_pkg::t_pc    i_jump_target,

    // Result channel.
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output sie_pkg::t_pc    o_next_pc,
    output logic            o_finished,
    output sie_pkg::t_q     o_result_value,
    output logic            o_wrote_variable,
    output logic            o_branch_taken,
    output logic            o_arith_fault,

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import sie_pkg::*;

    localparam int AW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
    localparam logic [16:0] DEPTH_LIM = 17'(SIE_PROG_DEPTH);

    // Instruction opcodes.
    localparam logic [2:0] OP_ASSIGN = 3'd0;
    localparam logic [2:0] OP_ARITH  = 3'd1;
    localparam logic [2:0] OP_BRANCH = 3'd2;
    localparam logic [2:0] OP_JUMP   = 3'd3;
    localparam logic [2:0] OP_HWRITE = 3'd5;
    localparam logic [2:0] OP_HREAD  = 3'd6;

    // Arithmetic operators.
    localparam logic [2:0] AR_ADD = 3'd0;
    localparam logic [2:0] AR_SUB = 3'd1;
    localparam logic [2:0] AR_MUL = 3'd2;
    localparam logic [2:0] AR_DIV = 3'd3;

    // Compare operators.
    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_NE = 3'd1;
    localparam logic [2:0] CMP_LT = 3'd2;
    localparam logic [2:0] CMP_LE = 3'd3;
    localparam logic [2:0] CMP_GT = 3'd4;
    localparam logic [2:0] CMP_GE = 3'd5;

    // The only configuration register, at word index 0.
    localparam logic REG_PROG_LEN = 1'b0;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDA,
        S_RDB,
        S_LDB,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DONE
    } t_state;

    // True when the program counter is at or past the effective program length.
    function automatic logic f_at_end(input t_pc pc, input logic [16:0] eff);
        return {5'd0, pc} >= eff;
    endfunction

    t_state   r_state;
    logic [AW-1:0] r_clr_addr;

    // Architectural state.
    t_pc      r_pc;
    logic     r_fin;
    t_pc      r_prog_len;

    // Latched request. The operand registers first hold the literals and are then replaced
    // by the variable file contents where the instruction asks for it.
    logic [2:0] r_op;
    logic [2:0] r_opr;
    t_idx       r_dest;
    logic       r_a_var;
    t_idx       r_a_idx;
    logic       r_b_var;
    t_idx       r_b_idx;
    t_pc        r_target;
    t_q         r_a;
    t_q         r_b;

    // Working result.
    logic signed [63:0] r_prod;
    t_q       r_res_val;
    logic     r_res_fault;
    logic     r_res_wr;
    logic     r_res_taken;
    t_pc      r_npc;
    logic     r_ndone;

    // Output register.
    logic     r_out_valid;
    t_pc      r_out_pc;
    logic     r_out_fin;
    t_q       r_out_val;
    logic     r_out_wr;
    logic     r_out_taken;
    logic     r_out_fault;

    logic [16:0]  w_eff;
    logic         w_a_ok;
    logic         w_b_ok;
    logic         w_dest_ok;
    logic         w_use_var_a;
    logic         w_run;
    logic         w_cond;
    logic         w_taken;
    t_pc          w_npc;
    logic signed [32:0] w_sum;
    logic         w_sum_ovf;
    t_q           w_sum_sat;
    logic         w_mul_ovf;
    logic         w_out_free;
    logic         w_div_start;
    logic         w_cfg_wr;
    t_div_res     w_div;

    logic          w_ram_we;
    logic [AW-1:0] w_ram_waddr;
    t_q            w_ram_wdata;
    logic [AW-1:0] w_ram_raddr;
    t_q            w_ram_rdata;

    // The effective length is the configured length clipped to the script store depth.
    assign w_eff = ({5'd0, r_prog_len} < DEPTH_LIM) ? {5'd0, r_prog_len} : DEPTH_LIM;

    // Indices at or beyond the variable count read as zero and are never written.
    assign w_a_ok    = int'(r_a_idx) < VAR_COUNT;
    assign w_b_ok    = int'(r_b_idx) < VAR_COUNT;
    assign w_dest_ok = int'(r_dest)  < VAR_COUNT;

    // Host read always takes its value from the file; host write always from the literal.
    assign w_use_var_a = (r_op == OP_HREAD) || ((r_op != OP_HWRITE) && r_a_var);

    // A script instruction runs only if the block is not finished and the counter is in range.
    assign w_run = !r_fin && !f_at_end(r_pc, w_eff);

    always_comb begin
        case (r_opr)
            CMP_EQ:  w_cond = (r_a == r_b);
            CMP_NE:  w_cond = (r_a != r_b);
            CMP_LT:  w_cond = (r_a <  r_b);
            CMP_LE:  w_cond = (r_a <= r_b);
            CMP_GT:  w_cond = (r_a >  r_b);
            CMP_GE:  w_cond = (r_a >= r_b);
            default: w_cond = 1'b0;
        endcase
    end

    assign w_taken = (r_op == OP_JUMP) || ((r_op == OP_BRANCH) && !w_cond);
    assign w_npc   = w_taken ? r_target : (r_pc + 12'd1);

    assign w_sum     = (r_opr == AR_SUB) ? (33'(r_a) - 33'(r_b)) : (33'(r_a) + 33'(r_b));
    assign w_sum_ovf = w_sum[32] != w_sum[31];
    assign w_sum_sat = w_sum_ovf ? (w_sum[32] ? Q_MIN : Q_MAX) : w_sum[31:0];

    // The shifted product fits in 32 bits only if bits 63 down to 47 are all sign copies.
    assign w_mul_ovf = !((&r_prod[63:47]) || (~|r_prod[63:47]));

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_div_start = (r_state == S_EXEC) && (r_op == OP_ARITH) && (r_opr == AR_DIV) && w_run;
    assign w_cfg_wr    = psel && penable && pwrite && pready;

    // Variable file: the clearing pass owns the write port after reset, the final step of a
    // request owns it afterwards. The read port serves operand a, then operand b.
    assign w_ram_we    = (r_state == S_CLEAR)
                      || ((r_state == S_DONE) && w_out_free && r_res_wr);
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : AW'(r_dest);
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0 : r_res_val;
    assign w_ram_raddr = (r_state == S_RDA) ? AW'(r_a_idx) : AW'(r_b_idx);

    sie_ram #(
        .WIDTH (32),
        .DEPTH (VAR_COUNT)
    ) u_var_file (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    sie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_pc        <= '0;
            r_fin       <= 1'b0;
            r_prog_len  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_PROG_LEN)) begin
                r_prog_len <= pwdata[11:0];
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(VAR_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= i_opcode;
                        r_opr    <= i_operator_code;
                        r_dest   <= i_dest_index;
                        r_a_var  <= i_a_from_var;
                        r_a_idx  <= i_a_index;
                        r_b_var  <= i_b_from_var;
                        r_b_idx  <= i_b_index;
                        r_target <= i_jump_target;
                        r_a      <= i_a_literal;
                        r_b      <= i_b_literal;
                        r_state  <= S_RDA;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    if (w_use_var_a) begin
                        r_a <= w_a_ok ? w_ram_rdata : '0;
                    end
                    r_state <= S_LDB;
                end
                S_LDB: begin
                    if (r_b_var) begin
                        r_b <= w_b_ok ? w_ram_rdata : '0;
                    end
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_prod      <= r_a * r_b;
                    r_res_val   <= '0;
                    r_res_fault <= 1'b0;
                    r_res_wr    <= 1'b0;
                    r_res_taken <= 1'b0;
                    r_npc       <= r_pc;
                    r_ndone     <= r_fin;
                    r_state     <= S_DONE;
                    case (r_op)
                        OP_HWRITE: begin
                            r_res_val <= r_a;
                            r_res_wr  <= w_dest_ok;
                        end
                        OP_HREAD: begin
                            r_res_val <= r_a;
                        end
                        default: begin
                            if (!r_fin && !w_run) begin
                                // Reaching the end before running finishes the script and
                                // drops the instruction.
                                r_ndone <= 1'b1;
                            end else if (w_run) begin
                                r_npc       <= w_npc;
                                r_res_taken <= w_taken;
                                r_ndone     <= f_at_end(w_npc, w_eff);
                                if (r_op == OP_ASSIGN) begin
                                    r_res_val <= r_a;
                                    r_res_wr  <= w_dest_ok;
                                end else if (r_op == OP_ARITH) begin
                                    case (r_opr)
                                        AR_ADD, AR_SUB: begin
                                            r_res_val   <= w_sum_sat;
                                            r_res_fault <= w_sum_ovf;
                                            r_res_wr    <= w_dest_ok;
                                        end
                                        AR_MUL: begin
                                            r_res_wr <= w_dest_ok;
                                            r_state  <= S_MUL;
                                        end
                                        AR_DIV: begin
                                            r_res_wr <= w_dest_ok;
                                            r_state  <= S_DIV;
                                        end
                                        default: begin
                                            // Unknown operators write nothing.
                                            r_res_wr <= 1'b0;
                                        end
                                    endcase
                                end
                            end
                        end
                    endcase
                end
                S_MUL: begin
                    r_res_fault <= w_mul_ovf;
                    if (w_mul_ovf) begin
                        r_res_val <= r_prod[63] ? Q_MIN : Q_MAX;
                    end else begin
                        r_res_val <= r_prod[47:16];
                    end
                    r_state <= S_DONE;
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_res_val   <= w_div.quot;
                        r_res_fault <= w_div.fault;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_pc    <= r_npc;
                        r_out_fin   <= r_ndone;
                        r_out_val   <= r_res_val;
                        r_out_wr    <= r_res_wr;
                        r_out_taken <= r_res_taken;
                        r_out_fault <= r_res_fault;
                        r_pc        <= r_npc;
                        r_fin       <= r_ndone;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_next_pc        = r_out_pc;
    assign o_finished       = r_out_fin;
    assign o_result_value   = r_out_val;
    assign o_wrote_variable = r_out_wr;
    assign o_branch_taken   = r_out_taken;
    assign o_arith_fault    = r_out_fault;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PROG_LEN) ? {20'd0, r_prog_len} : 32'd0;

endmodule

`default_nettype wire
